>>> hdl/bdme_pkg.sv
// Package: beat types, per-button state type and message codes for the button debounce block.
package bdme_pkg;

  // Input beat: one raw sample of one button plus that button's settings.
  typedef struct packed {
    logic [5:0] button_id;
    logic       raw_level;
    logic       debounce_enable;
    logic [1:0] button_mode;
    logic [3:0] message_kind;
    logic [6:0] note_number;
    logic [3:0] midi_channel;
    logic [6:0] on_velocity;
  } in_t;

  // Result beat: one MIDI event.
  typedef struct packed {
    logic [2:0] event_kind;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [3:0] out_channel;
  } out_t;

  // Per-button state word held in the state memory.
  typedef struct packed {
    logic [2:0] hist;
    logic       last;
    logic       pressed;
  } btn_state_t;

  // Button types
  localparam logic [1:0] MODE_MOMENTARY = 2'd0;
  localparam logic [1:0] MODE_LATCHING  = 2'd1;

  // Message kinds
  localparam logic [3:0] MK_NOTE       = 4'd0;
  localparam logic [3:0] MK_PROGRAM    = 4'd1;
  localparam logic [3:0] MK_CC         = 4'd2;
  localparam logic [3:0] MK_CC_RESET   = 4'd3;
  localparam logic [3:0] MK_MMC_PLAY   = 4'd4;
  localparam logic [3:0] MK_MMC_STOP   = 4'd5;
  localparam logic [3:0] MK_MMC_PAUSE  = 4'd6;
  localparam logic [3:0] MK_MMC_RECORD = 4'd7;
  localparam logic [3:0] MK_RT_FIRST   = 4'd8;
  localparam logic [3:0] MK_RT_LAST    = 4'd13;

  // Event kinds
  localparam logic [2:0] EV_NOTE_ON  = 3'd0;
  localparam logic [2:0] EV_NOTE_OFF = 3'd1;
  localparam logic [2:0] EV_PROGRAM  = 3'd2;
  localparam logic [2:0] EV_CC       = 3'd3;
  localparam logic [2:0] EV_MMC      = 3'd4;
  localparam logic [2:0] EV_REALTIME = 3'd5;

  // MMC command bytes
  localparam logic [6:0] MMC_PLAY       = 7'h02;
  localparam logic [6:0] MMC_STOP       = 7'h01;
  localparam logic [6:0] MMC_PAUSE      = 7'h09;
  localparam logic [6:0] MMC_RECORD_ON  = 7'h06;
  localparam logic [6:0] MMC_RECORD_OFF = 7'h07;

  localparam logic [2:0] HIST_ALL_ONE = 3'b111;

endpackage

>>> hdl/bdme_core.sv
// Event logic: debounce, type override and momentary/latching handling for one sample.
module bdme_core (
  input  bdme_pkg::in_t        item,
  input  bdme_pkg::btn_state_t cur,
  output bdme_pkg::btn_state_t nxt,
  output logic                 res_vld,
  output bdme_pkg::out_t       res
);
  import bdme_pkg::*;

  logic [2:0] hist_shift;
  logic       accepted;
  logic [1:0] mode;
  logic       level;
  logic [3:0] kind;

  always_comb begin
    level      = item.raw_level;
    kind       = item.message_kind;
    hist_shift = {cur.hist[1:0], level};
    nxt        = cur;
    res_vld    = 1'b0;
    res        = '0;
    accepted   = 1'b1;

    if (item.debounce_enable) begin
      nxt.hist = hist_shift;
      accepted = (hist_shift == 3'b000) || (hist_shift == HIST_ALL_ONE);
    end

    case (kind) inside
      MK_MMC_RECORD:                                     mode = MODE_LATCHING;
      MK_PROGRAM, MK_CC, [MK_MMC_PLAY:MK_MMC_PAUSE],
      [MK_RT_FIRST:MK_RT_LAST]:                          mode = MODE_MOMENTARY;
      default:                                           mode = item.button_mode;
    endcase

    if (accepted) begin
      nxt.last = level;
      if (mode == MODE_MOMENTARY) begin
        if (level && !cur.pressed) begin
          nxt.pressed = 1'b1;
          res_vld     = 1'b1;
          res.data_first  = item.note_number;
          res.out_channel = item.midi_channel;
          case (kind) inside
            MK_NOTE: begin
              res.event_kind  = EV_NOTE_ON;
              res.data_second = item.on_velocity;
            end
            MK_PROGRAM: res.event_kind = EV_PROGRAM;
            MK_CC, MK_CC_RESET: begin
              res.event_kind  = EV_CC;
              res.data_second = item.on_velocity;
            end
            MK_MMC_PLAY, MK_MMC_STOP, MK_MMC_PAUSE: begin
              res.event_kind  = EV_MMC;
              res.out_channel = '0;
              res.data_second = (kind == MK_MMC_PLAY) ? MMC_PLAY :
                                (kind == MK_MMC_STOP) ? MMC_STOP : MMC_PAUSE;
            end
            [MK_RT_FIRST:MK_RT_LAST]: begin
              // realtime code is kind - 8, i.e. the low three bits
              res.event_kind  = EV_REALTIME;
              res.data_first  = {4'd0, kind[2:0]};
              res.out_channel = '0;
            end
            default: res_vld = 1'b0;
          endcase
        end else if (!level && cur.pressed) begin
          nxt.pressed     = 1'b0;
          res.data_first  = item.note_number;
          res.out_channel = item.midi_channel;
          if (kind == MK_NOTE) begin
            res_vld        = 1'b1;
            res.event_kind = EV_NOTE_OFF;
          end else if (kind == MK_CC_RESET) begin
            res_vld        = 1'b1;
            res.event_kind = EV_CC;
          end
        end
      end else if (mode == MODE_LATCHING) begin
        if (level && !cur.last) begin
          nxt.pressed     = !cur.pressed;
          res.data_first  = item.note_number;
          res.out_channel = item.midi_channel;
          case (kind)
            MK_NOTE: begin
              res_vld         = 1'b1;
              res.event_kind  = cur.pressed ? EV_NOTE_OFF : EV_NOTE_ON;
              res.data_second = cur.pressed ? 7'd0 : item.on_velocity;
            end
            MK_CC_RESET: begin
              res_vld         = 1'b1;
              res.event_kind  = EV_CC;
              res.data_second = cur.pressed ? 7'd0 : item.on_velocity;
            end
            MK_MMC_RECORD: begin
              res_vld         = 1'b1;
              res.event_kind  = EV_MMC;
              res.out_channel = '0;
              res.data_second = cur.pressed ? MMC_RECORD_OFF : MMC_RECORD_ON;
            end
            default: res_vld = 1'b0;
          endcase
        end
      end
    end
  end

endmodule

>>> hdl/button_debounce_midi_event.sv
// Top level: per-button debounce and MIDI event generator with state memory.
//
// Input channel (in_valid/in_ready/in_data) takes one raw sample of one button
// per beat, with that button's type, message kind, number, channel and
// velocity. The result channel (out_valid/out_ready/out_data) carries zero or
// one MIDI event per input beat, in input order.
//
// Pipeline: a beat is accepted into an input register while the button's state
// word is read from memory; the event logic then runs on that register and the
// event lands in the output register. Throughput is one beat per cycle while the
// output is not stalled, also on repeated samples of the same button: a state
// word written back in the cycle a new beat is read is forwarded to it.
//
// Reset clears the pipeline and output valids and the per-button valid bits;
// a button whose state was never written reads as all zero. When the receiver
// stalls, the output register holds and the input stage stops once its beat
// has an event waiting; beats that make no event still pass through.
module button_debounce_midi_event #(
  parameter int BUTTON_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bdme_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bdme_pkg::out_t out_data
);
  import bdme_pkg::*;

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [8:0] CNT_LIM = 9'(BUTTON_COUNT);

  btn_state_t mem [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] btn_vld_r;

  logic             in_fire;
  logic [IDX_W-1:0] in_addr;
  logic             in_range;

  logic             s1_vld_r;
  in_t              s1_item_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic             s1_inr_r;
  btn_state_t       mem_q_r;
  logic             vld_q_r;
  logic             fwd_r;
  btn_state_t       fwd_dat_r;

  btn_state_t cur_state;
  btn_state_t nxt_state;
  logic       res_vld;
  out_t       res;

  logic       out_vld_r;
  out_t       out_data_r;

  logic s1_go;
  logic wr_en;

  assign in_addr  = IDX_W'(in_data.button_id);
  assign in_range = {3'b000, in_data.button_id} < CNT_LIM;

  assign cur_state = fwd_r ? fwd_dat_r : (vld_q_r ? mem_q_r : '0);

  bdme_core u_core (
    .item    (s1_item_r),
    .cur     (cur_state),
    .nxt     (nxt_state),
    .res_vld (res_vld),
    .res     (res)
  );

  // stage 1 retires when its event, if any, has room in the output register
  assign s1_go    = s1_vld_r && (!out_vld_r || out_ready || !(res_vld && s1_inr_r));
  assign in_ready = !s1_vld_r || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_go && s1_inr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= nxt_state;
    end
    if (in_fire) begin
      mem_q_r   <= mem[in_addr];
      vld_q_r   <= btn_vld_r[in_addr];
      fwd_r     <= wr_en && (s1_addr_r == in_addr);
      fwd_dat_r <= nxt_state;
      s1_item_r <= in_data;
      s1_addr_r <= in_addr;
      s1_inr_r  <= in_range;
    end
    if (s1_go && res_vld && s1_inr_r) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      btn_vld_r <= '0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_go && res_vld && s1_inr_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        btn_vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/bdme_checker.sv
// Port checker for the button debounce block, bound to the top level.
module bdme_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input bdme_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input bdme_pkg::out_t out_data
);
  import bdme_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // MMC and realtime events carry channel zero
  a_sys_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_MMC || out_data.event_kind == EV_REALTIME)
    |-> out_data.out_channel == 4'd0)
    else $error("system event with non-zero channel");

  // events without a second data byte send it as zero
  a_zero_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_NOTE_OFF ||
                  out_data.event_kind == EV_PROGRAM ||
                  out_data.event_kind == EV_REALTIME)
    |-> out_data.data_second == 7'd0)
    else $error("non-zero second data byte");

  // only defined event kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_kind <= EV_REALTIME)
    else $error("undefined event kind");

endmodule

bind button_debounce_midi_event bdme_checker u_bdme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/testbench.sv
// Testbench for button_debounce_midi_event: queued sample stimulus, event predictor, checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdme_pkg::*;

  localparam int N_BEATS    = 1050;
  localparam int CYCLE_CAP  = 200000;
  localparam int PHASE_LEN  = 100;
  localparam int MAX_REPORT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // per-button view of the debounce and press state
  logic [2:0] hist_mem [64];
  logic       last_mem [64];
  logic       held_mem [64];

  in_t  sample_q [$];
  out_t event_q  [$];

  int beats_sent  = 0;
  int events_seen = 0;
  int mismatches  = 0;
  int cycle_cnt   = 0;
  int kind_cnt [8];
  int phase;

  button_debounce_midi_event dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // idling pattern changes every PHASE_LEN beats: none, sender, receiver, both
  assign phase = (beats_sent / PHASE_LEN) % 4;

  function automatic bit predict_event(input in_t s, output out_t ev);
    logic [2:0] h;
    logic [1:0] mode;
    logic [5:0] id;
    bit         hit;
    hit  = 1'b0;
    ev   = '0;
    id   = s.button_id;
    mode = s.button_mode;
    if (s.debounce_enable) begin
      h = {hist_mem[id][1:0], s.raw_level};
      hist_mem[id] = h;
      if (h != 3'b000 && h != HIST_ALL_ONE) return 1'b0;
    end
    if (s.message_kind == MK_MMC_RECORD)
      mode = MODE_LATCHING;
    else if (s.message_kind == MK_PROGRAM || s.message_kind == MK_CC ||
             (s.message_kind >= MK_MMC_PLAY && s.message_kind <= MK_MMC_PAUSE) ||
             (s.message_kind >= MK_RT_FIRST && s.message_kind <= MK_RT_LAST))
      mode = MODE_MOMENTARY;

    if (mode == MODE_MOMENTARY) begin
      if (s.raw_level) begin
        if (!held_mem[id]) begin
          held_mem[id] = 1'b1;
          hit = 1'b1;
          case (s.message_kind)
            MK_NOTE: ev = {EV_NOTE_ON, s.note_number, s.on_velocity, s.midi_channel};
            MK_PROGRAM: ev = {EV_PROGRAM, s.note_number, 7'd0, s.midi_channel};
            MK_CC, MK_CC_RESET: ev = {EV_CC, s.note_number, s.on_velocity, s.midi_channel};
            MK_MMC_PLAY: ev = {EV_MMC, s.note_number, MMC_PLAY, 4'd0};
            MK_MMC_STOP: ev = {EV_MMC, s.note_number, MMC_STOP, 4'd0};
            MK_MMC_PAUSE: ev = {EV_MMC, s.note_number, MMC_PAUSE, 4'd0};
            default: begin
              if (s.message_kind >= MK_RT_FIRST && s.message_kind <= MK_RT_LAST)
                ev = {EV_REALTIME, 3'd0, s.message_kind - MK_RT_FIRST, 7'd0, 4'd0};
              else
                hit = 1'b0;
            end
          endcase
        end
      end else if (held_mem[id]) begin
        held_mem[id] = 1'b0;
        if (s.message_kind == MK_NOTE) begin
          hit = 1'b1;
          ev  = {EV_NOTE_OFF, s.note_number, 7'd0, s.midi_channel};
        end else if (s.message_kind == MK_CC_RESET) begin
          hit = 1'b1;
          ev  = {EV_CC, s.note_number, 7'd0, s.midi_channel};
        end
      end
    end else if (mode == MODE_LATCHING) begin
      // toggle only on a rising accepted level
      if (s.raw_level && !last_mem[id]) begin
        held_mem[id] = ~held_mem[id];
        hit = 1'b1;
        if (s.message_kind == MK_NOTE)
          ev = held_mem[id] ? {EV_NOTE_ON, s.note_number, s.on_velocity, s.midi_channel}
                            : {EV_NOTE_OFF, s.note_number, 7'd0, s.midi_channel};
        else if (s.message_kind == MK_MMC_RECORD)
          ev = {EV_MMC, s.note_number, held_mem[id] ? MMC_RECORD_ON : MMC_RECORD_OFF, 4'd0};
        else if (s.message_kind == MK_CC_RESET)
          ev = {EV_CC, s.note_number, held_mem[id] ? s.on_velocity : 7'd0, s.midi_channel};
        else
          hit = 1'b0;
      end
    end
    last_mem[id] = s.raw_level;
    return hit;
  endfunction

  task automatic push_beat(input in_t b, input logic lvl);
    b.raw_level = lvl;
    sample_q.push_back(b);
  endtask

  // one press or release: optional bounce, then a steady run of the wanted level
  task automatic add_stroke(input in_t b, input logic lvl);
    int n;
    if (b.debounce_enable) begin
      n = $urandom_range(0, 2);
      repeat (n) push_beat(b, 1'($urandom));
      n = ($urandom_range(0, 9) == 0) ? 2 : 3 + $urandom_range(0, 1);
    end else begin
      n = 1 + $urandom_range(0, 1);
    end
    repeat (n) push_beat(b, lvl);
  endtask

  // driver
  always @(posedge clk) begin
    in_t        b;
    out_t       ev;
    logic       take;
    int         idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        if (predict_event(in_data, ev)) event_q.push_back(ev);
        beats_sent <= beats_sent + 1;
      end
      if (!in_valid || take) begin
        idle_pct = (phase == 1) ? 65 : (phase == 3) ? 34 : 0;
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          b = sample_q.pop_front();
          in_data  <= b;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_ev;
    int   stall_pct;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        events_seen <= events_seen + 1;
        kind_cnt[out_data.event_kind] <= kind_cnt[out_data.event_kind] + 1;
        if (event_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORT)
            $display("[%0t] unexpected event: kind %0d first %0d second %0d chan %0d",
                     $realtime, out_data.event_kind, out_data.data_first,
                     out_data.data_second, out_data.out_channel);
        end else begin
          exp_ev = event_q.pop_front();
          if (out_data.event_kind !== exp_ev.event_kind ||
              out_data.data_first !== exp_ev.data_first ||
              out_data.data_second !== exp_ev.data_second ||
              out_data.out_channel !== exp_ev.out_channel) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORT)
              $display("[%0t] event mismatch: exp kind %0d first %0d second %0d chan %0d, got kind %0d first %0d second %0d chan %0d",
                       $realtime, exp_ev.event_kind, exp_ev.data_first,
                       exp_ev.data_second, exp_ev.out_channel, out_data.event_kind,
                       out_data.data_first, out_data.data_second, out_data.out_channel);
          end
        end
      end
      stall_pct = (phase == 2) ? 65 : (phase == 3) ? 34 : 0;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_t b;
    for (int i = 0; i < 64; i++) begin
      hist_mem[i] = '0;
      last_mem[i] = 1'b0;
      held_mem[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) kind_cnt[i] = 0;

    // every message kind pressed once on its own button, field extremes alternating
    for (int k = 0; k < 16; k++) begin
      b.button_id       = 6'(k);
      b.debounce_enable = 1'b0;
      b.button_mode     = (k == 14) ? MODE_LATCHING : MODE_MOMENTARY;
      b.message_kind    = 4'(k);
      b.note_number     = (k % 2 == 0) ? 7'd127 : 7'd0;
      b.midi_channel    = (k % 4 < 2) ? 4'd15 : 4'd0;
      b.on_velocity     = (k % 8 < 4) ? 7'd127 : 7'd0;
      push_beat(b, 1'b1);
    end
    // releases: note off, CC-reset back to zero, record latch ignores release
    b = sample_q[0];  push_beat(b, 1'b0);
    b = sample_q[3];  push_beat(b, 1'b0);
    b = sample_q[7];  push_beat(b, 1'b0);
    push_beat(b, 1'b1);
    // debounced press with a bounce on a high button
    b.button_id       = 6'd63;
    b.debounce_enable = 1'b1;
    b.button_mode     = MODE_MOMENTARY;
    b.message_kind    = MK_NOTE;
    b.note_number     = 7'd64;
    b.midi_channel    = 4'd9;
    b.on_velocity     = 7'd100;
    push_beat(b, 1'b1);
    push_beat(b, 1'b0);
    push_beat(b, 1'b1);
    push_beat(b, 1'b1);
    push_beat(b, 1'b1);

    // press/release gestures with random settings, mixed with raw noise
    while (sample_q.size() < N_BEATS) begin
      if ($urandom_range(0, 99) < 12) begin
        b = in_t'(21'($urandom));
        sample_q.push_back(b);
      end else begin
        b.button_id = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 11))
                                                   : 6'($urandom_range(0, 63));
        b.debounce_enable = ($urandom_range(0, 99) < 75);
        b.button_mode     = ($urandom_range(0, 99) < 10) ? 2'($urandom_range(2, 3))
                                                         : 2'($urandom_range(0, 1));
        b.message_kind    = 4'($urandom);
        b.note_number     = 7'($urandom);
        b.midi_channel    = 4'($urandom);
        b.on_velocity     = 7'($urandom);
        add_stroke(b, 1'b1);
        if ($urandom_range(0, 99) < 10) b.message_kind = 4'($urandom);
        if ($urandom_range(0, 99) < 80) add_stroke(b, 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_q.size() != 0 || in_valid) @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d sample beats over four idling patterns, %0d events checked", beats_sent,
             events_seen);
    $display("events by kind: note on %0d, note off %0d, program %0d, cc %0d, mmc %0d, rt %0d",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4], kind_cnt[5]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d bad events", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
